[design/fet_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fet_pkg: shared types and helpers for the filter expression tokenizer
// character classes, result kinds, result record and word append helper
// ----------------------------------------------------------------------------
package fet_pkg;

	localparam int NUM_W        = 32;   // number accumulator width
	localparam int OUT_NUM_W    = 32;   // width of int_part and frac_part
	localparam int FIFO_DEPTH   = 4;
	localparam int PTR_W        = $clog2(FIFO_DEPTH);
	localparam int CNT_W        = $clog2(FIFO_DEPTH + 1);
	localparam int TDATA_W      = 96;
	localparam logic [7:0] MAX_WORD_RESET = 8'd200;
	localparam logic [3:0] FRAC_SAT = 4'd15;

	// character codes
	localparam logic [7:0] CH_QUOTE  = 8'h27;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_MINUS  = 8'h2d;
	localparam logic [7:0] CH_DOT    = 8'h2e;
	localparam logic [7:0] CH_SLASH  = 8'h2f;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0a;
	localparam logic [7:0] CH_ZERO   = 8'h30;

	typedef enum logic [3:0] {
		K_WORD_CHAR = 4'd0,
		K_SYMBOL    = 4'd1,
		K_INT       = 4'd2,
		K_DECIMAL   = 4'd3,
		K_STR_END   = 4'd4,
		K_VAR_END   = 4'd5,
		K_COMP_END  = 4'd6,
		K_PATH_END  = 4'd7,
		K_END       = 4'd8,
		K_BAD_CHAR  = 4'd9,
		K_TOO_LONG  = 4'd10
	} kind_t;

	typedef struct packed {
		kind_t                  kind;
		logic [3:0]             symbol;
		logic [7:0]             word_char;
		logic                   negative;
		logic [OUT_NUM_W-1:0]   int_part;
		logic [OUT_NUM_W-1:0]   frac_part;
		logic [3:0]             frac_digits;
		logic                   has_field;
		logic [7:0]             word_length;
		logic                   last;
	} res_t;

	typedef struct packed {
		res_t       res;
		logic       halt;
		logic [7:0] count;
	} app_t;

	typedef struct packed {
		logic       hit;
		logic [3:0] code;
	} sym_t;

	function automatic logic is_dig(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a))
			|| (c == 8'h5f);
	endfunction

	// symbol table ( ) & | = ~ < > ! ?
	function automatic sym_t sym_lookup(input logic [7:0] c);
		sym_t s;
		s.hit = 1'b1;
		case (c)
			8'h28:   s.code = 4'd0;
			8'h29:   s.code = 4'd1;
			8'h26:   s.code = 4'd2;
			8'h7c:   s.code = 4'd3;
			8'h3d:   s.code = 4'd4;
			8'h7e:   s.code = 4'd5;
			8'h3c:   s.code = 4'd6;
			8'h3e:   s.code = 4'd7;
			8'h21:   s.code = 4'd8;
			8'h3f:   s.code = 4'd9;
			default: begin
				s.hit  = 1'b0;
				s.code = 4'd0;
			end
		endcase
		return s;
	endfunction

	// one character appended to a word, with the length limit
	function automatic app_t word_append(input logic [7:0] base, input logic [7:0] c,
			input logic [7:0] max_word);
		app_t a;
		logic [7:0] n;
		n = base + 8'd1;
		a = '0;
		a.res.word_char = c;
		a.count = n;
		if (n >= max_word) begin
			a.res.kind = K_TOO_LONG;
			a.res.word_length = n;
			a.halt = 1'b1;
		end else begin
			a.res.kind = K_WORD_CHAR;
		end
		return a;
	endfunction

endpackage
`default_nettype wire

[design/filter_expression_tokenizer.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// filter_expression_tokenizer
// streaming tokenizer for subscription filter expressions
// ----------------------------------------------------------------------------
// usage
//   s_axis: one transfer per character; tuser = op (0 character, 1 end of text),
//     tdata = the character byte
//   m_axis: one transfer per result; tuser = kind, tlast marks the last result
//     caused by one input, tdata carries the token fields
//   cfg_wen/cfg_wdata: writes max_word at any edge with cfg_wen high; write it
//     only while no character is in flight
// data path: an accepted character waits in the input register, is tokenised
//   combinationally there and its results are written to the queue once at
//   most two entries are used; the queue head drives m_axis
// throughput: one character per cycle while each gives at most one result and
//   m_axis_tready is high; the output drains one result per cycle, so inputs
//   giving two results fill the four-entry queue and then slow the input side
// stall: while the receiver holds m_axis_tready low the queue fills; the input
//   register waits until at most two entries are used and s_axis_tready stays
//   low meanwhile
// reset: queue empty, tokenizer at token start, max_word back to 200
// ----------------------------------------------------------------------------
module filter_expression_tokenizer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input characters
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] ch
	input  wire logic        s_axis_tuser,   // [0] op
	// results
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [3:0] symbol, [11:4] word_char, [12] negative, [44:13] int_part,
	// [76:45] frac_part, [80:77] frac_digits, [81] has_field,
	// [89:82] word_length, [95:90] zero
	output logic [95:0]      m_axis_tdata,
	output logic [3:0]       m_axis_tuser,   // [3:0] kind
	output logic             m_axis_tlast,
	// configuration
	input  wire logic        cfg_wen,
	input  wire logic [7:0]  cfg_wdata
);

	typedef enum logic [2:0] {
		M_START, M_NUMBER, M_STRING, M_VARIABLE, M_PATH, M_HALT
	} mode_t;

	// input register
	logic        valid_s1;
	logic        op_s1;
	logic [7:0]  ch_s1;

	// tokenizer state
	mode_t                      mode_q;
	logic [7:0]                 word_count_q;
	logic                       field_seen_q;
	logic                       hash_word_q;
	logic                       minus_seen_q;
	logic                       is_decimal_q;
	logic [fet_pkg::NUM_W-1:0]  int_acc_q;
	logic [fet_pkg::NUM_W-1:0]  frac_acc_q;
	logic [3:0]                 frac_count_q;
	logic [7:0]                 max_word_q;

	// result queue
	fet_pkg::res_t              fifo_q [fet_pkg::FIFO_DEPTH];
	logic [fet_pkg::PTR_W-1:0]  wr_ptr_q;
	logic [fet_pkg::PTR_W-1:0]  rd_ptr_q;
	logic [fet_pkg::CNT_W-1:0]  count_q;

	logic adv;
	logic pop;

	// next state and results
	mode_t                      mode_n;
	logic [7:0]                 word_count_n;
	logic                       field_seen_n;
	logic                       hash_word_n;
	logic                       minus_seen_n;
	logic                       is_decimal_n;
	logic [fet_pkg::NUM_W-1:0]  int_acc_n;
	logic [fet_pkg::NUM_W-1:0]  frac_acc_n;
	logic [3:0]                 frac_count_n;
	fet_pkg::res_t              pre;
	fet_pkg::res_t              post;
	logic                       pre_v;
	logic                       post_v;
	fet_pkg::res_t              e0;
	fet_pkg::res_t              e1;
	logic [1:0]                 n_push;

	// queue has room for the two results an input may cause
	assign adv = valid_s1 && (count_q <= fet_pkg::CNT_W'(fet_pkg::FIFO_DEPTH - 2));
	assign s_axis_tready = !valid_s1 || adv;
	assign pop = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			op_s1 <= s_axis_tuser;
			ch_s1 <= s_axis_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_word_q <= fet_pkg::MAX_WORD_RESET;
		end else if (cfg_wen) begin
			max_word_q <= cfg_wdata;
		end
	end

	// tokenizer step: token end or word character (pre), then the character
	// restarted as a new token, a field word opened, or the end token (post)
	always_comb begin
		logic                   do_start;
		logic                   slash_dot;
		logic                   stop;
		logic [3:0]             dval;
		fet_pkg::app_t          ap;
		fet_pkg::sym_t          sy;
		fet_pkg::res_t          num_res;
		fet_pkg::res_t          path_res;

		mode_n       = mode_q;
		word_count_n = word_count_q;
		field_seen_n = field_seen_q;
		hash_word_n  = hash_word_q;
		minus_seen_n = minus_seen_q;
		is_decimal_n = is_decimal_q;
		int_acc_n    = int_acc_q;
		frac_acc_n   = frac_acc_q;
		frac_count_n = frac_count_q;
		pre    = '0;
		post   = '0;
		pre_v  = 1'b0;
		post_v = 1'b0;
		do_start = 1'b0;
		dval = ch_s1[3:0] - fet_pkg::CH_ZERO[3:0];
		slash_dot = (ch_s1 == fet_pkg::CH_SLASH) || (ch_s1 == fet_pkg::CH_DOT);
		ap = '0;
		sy = fet_pkg::sym_lookup(ch_s1);

		// finished number
		num_res = '0;
		num_res.kind = is_decimal_q ? fet_pkg::K_DECIMAL : fet_pkg::K_INT;
		num_res.negative = minus_seen_q;
		num_res.int_part = fet_pkg::OUT_NUM_W'(int_acc_q);
		if (is_decimal_q) begin
			num_res.frac_part = fet_pkg::OUT_NUM_W'(frac_acc_q);
			num_res.frac_digits = frac_count_q;
		end

		// finished path
		path_res = '0;
		path_res.kind = fet_pkg::K_PATH_END;
		path_res.has_field = field_seen_q;
		path_res.word_length = word_count_q;

		// path stop rule
		if (slash_dot) begin
			stop = field_seen_q;
		end else if (ch_s1 == fet_pkg::CH_HASH) begin
			stop = (word_count_q != 8'd0);
		end else if (fet_pkg::is_dig(ch_s1)) begin
			stop = (word_count_q == 8'd0);
		end else if (fet_pkg::is_alpha(ch_s1)) begin
			stop = hash_word_q;
		end else begin
			stop = 1'b1;
		end

		if (op_s1) begin
			// end of text
			unique case (mode_q)
				M_STRING: begin
					pre_v = 1'b1;
					pre.kind = fet_pkg::K_STR_END;
					pre.word_length = word_count_q;
				end
				M_VARIABLE: begin
					pre_v = 1'b1;
					pre.kind = fet_pkg::K_VAR_END;
					pre.word_length = word_count_q;
				end
				M_NUMBER: begin
					pre_v = 1'b1;
					pre = num_res;
				end
				M_PATH: begin
					pre_v = 1'b1;
					pre = path_res;
				end
				default: begin
				end
			endcase
			post_v = 1'b1;
			post.kind = fet_pkg::K_END;
			mode_n       = M_START;
			word_count_n = 8'd0;
			field_seen_n = 1'b0;
			hash_word_n  = 1'b0;
			minus_seen_n = 1'b0;
			is_decimal_n = 1'b0;
			int_acc_n    = '0;
			frac_acc_n   = '0;
			frac_count_n = 4'd0;
		end else begin
			unique case (mode_q)
				M_START: begin
					do_start = 1'b1;
				end
				M_NUMBER: begin
					if (fet_pkg::is_dig(ch_s1)) begin
						if (!is_decimal_q) begin
							int_acc_n = (int_acc_q << 3) + (int_acc_q << 1)
								+ fet_pkg::NUM_W'(dval);
						end else begin
							frac_acc_n = (frac_acc_q << 3) + (frac_acc_q << 1)
								+ fet_pkg::NUM_W'(dval);
							if (frac_count_q < fet_pkg::FRAC_SAT) begin
								frac_count_n = frac_count_q + 4'd1;
							end
						end
					end else if ((ch_s1 == fet_pkg::CH_DOT) && !is_decimal_q) begin
						is_decimal_n = 1'b1;
					end else begin
						pre_v = 1'b1;
						pre = num_res;
						mode_n = M_START;
						do_start = 1'b1;
					end
				end
				M_STRING: begin
					pre_v = 1'b1;
					if (ch_s1 == fet_pkg::CH_QUOTE) begin
						pre.kind = fet_pkg::K_STR_END;
						pre.word_length = word_count_q;
						mode_n = M_START;
					end else begin
						ap = fet_pkg::word_append(word_count_q, ch_s1, max_word_q);
						pre = ap.res;
						word_count_n = ap.count;
						if (ap.halt) begin
							mode_n = M_HALT;
						end
					end
				end
				M_VARIABLE: begin
					pre_v = 1'b1;
					if (fet_pkg::is_alpha(ch_s1) || fet_pkg::is_dig(ch_s1)) begin
						ap = fet_pkg::word_append(word_count_q, ch_s1, max_word_q);
						pre = ap.res;
						word_count_n = ap.count;
						if (ap.halt) begin
							mode_n = M_HALT;
						end
					end else begin
						pre.kind = fet_pkg::K_VAR_END;
						pre.word_length = word_count_q;
						mode_n = M_START;
						do_start = 1'b1;
					end
				end
				M_PATH: begin
					pre_v = 1'b1;
					if (stop) begin
						pre = path_res;
						mode_n = M_START;
						do_start = 1'b1;
					end else if (slash_dot) begin
						// component boundary, a dot also opens the field word
						pre.kind = fet_pkg::K_COMP_END;
						pre.word_length = word_count_q;
						word_count_n = 8'd0;
						hash_word_n = 1'b0;
						if (ch_s1 == fet_pkg::CH_DOT) begin
							field_seen_n = 1'b1;
							ap = fet_pkg::word_append(8'd0, ch_s1, max_word_q);
							post_v = 1'b1;
							post = ap.res;
							word_count_n = ap.count;
							if (ap.halt) begin
								mode_n = M_HALT;
							end
						end
					end else begin
						if (ch_s1 == fet_pkg::CH_HASH) begin
							hash_word_n = 1'b1;
						end
						ap = fet_pkg::word_append(word_count_q, ch_s1, max_word_q);
						pre = ap.res;
						word_count_n = ap.count;
						if (ap.halt) begin
							mode_n = M_HALT;
						end
					end
				end
				default: begin
					// halted: characters are dropped
				end
			endcase
		end

		// start of a new token
		if (do_start) begin
			if (ch_s1 == fet_pkg::CH_QUOTE) begin
				word_count_n = 8'd0;
				mode_n = M_STRING;
			end else if (ch_s1 == fet_pkg::CH_DOLLAR) begin
				word_count_n = 8'd0;
				mode_n = M_VARIABLE;
			end else if (fet_pkg::is_dig(ch_s1) || (ch_s1 == fet_pkg::CH_MINUS)) begin
				minus_seen_n = (ch_s1 == fet_pkg::CH_MINUS);
				int_acc_n = (ch_s1 == fet_pkg::CH_MINUS) ? '0 : fet_pkg::NUM_W'(dval);
				frac_acc_n = '0;
				frac_count_n = 4'd0;
				is_decimal_n = 1'b0;
				mode_n = M_NUMBER;
			end else if (fet_pkg::is_alpha(ch_s1)) begin
				field_seen_n = 1'b0;
				hash_word_n = 1'b0;
				ap = fet_pkg::word_append(8'd0, ch_s1, max_word_q);
				post_v = 1'b1;
				post = ap.res;
				word_count_n = ap.count;
				mode_n = ap.halt ? M_HALT : M_PATH;
			end else if ((ch_s1 == fet_pkg::CH_SPACE) || (ch_s1 == fet_pkg::CH_TAB)
					|| (ch_s1 == fet_pkg::CH_LF)) begin
				// whitespace between tokens
			end else if (sy.hit) begin
				post_v = 1'b1;
				post.kind = fet_pkg::K_SYMBOL;
				post.symbol = sy.code;
			end else begin
				post_v = 1'b1;
				post.kind = fet_pkg::K_BAD_CHAR;
				post.word_char = ch_s1;
				mode_n = M_HALT;
			end
		end

		// last marks the final result of this input
		pre.last  = !post_v;
		post.last = 1'b1;
	end

	// queue entries in order
	always_comb begin
		e0 = pre_v ? pre : post;
		e1 = post;
		n_push = {1'b0, pre_v} + {1'b0, post_v};
	end

	// tokenizer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= M_START;
			word_count_q <= 8'd0;
			field_seen_q <= 1'b0;
			hash_word_q  <= 1'b0;
			minus_seen_q <= 1'b0;
			is_decimal_q <= 1'b0;
			int_acc_q    <= '0;
			frac_acc_q   <= '0;
			frac_count_q <= 4'd0;
		end else if (adv) begin
			mode_q       <= mode_n;
			word_count_q <= word_count_n;
			field_seen_q <= field_seen_n;
			hash_word_q  <= hash_word_n;
			minus_seen_q <= minus_seen_n;
			is_decimal_q <= is_decimal_n;
			int_acc_q    <= int_acc_n;
			frac_acc_q   <= frac_acc_n;
			frac_count_q <= frac_count_n;
		end
	end

	// result queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (adv) begin
				wr_ptr_q <= wr_ptr_q + fet_pkg::PTR_W'(n_push);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + fet_pkg::PTR_W'(1);
			end
			count_q <= count_q + (adv ? fet_pkg::CNT_W'(n_push) : '0)
				- fet_pkg::CNT_W'(pop);
		end
	end

	// result queue storage
	always_ff @(posedge clk) begin
		if (adv && (n_push != 2'd0)) begin
			fifo_q[wr_ptr_q] <= e0;
		end
		if (adv && (n_push == 2'd2)) begin
			fifo_q[wr_ptr_q + fet_pkg::PTR_W'(1)] <= e1;
		end
	end

	// output side
	fet_pkg::res_t head;
	assign head = fifo_q[rd_ptr_q];
	assign m_axis_tvalid = (count_q != '0);
	assign m_axis_tuser  = head.kind;
	assign m_axis_tlast  = head.last;
	assign m_axis_tdata  = {6'd0, head.word_length, head.has_field, head.frac_digits,
		head.frac_part, head.int_part, head.negative, head.word_char, head.symbol};

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= fet_pkg::CNT_W'(fet_pkg::FIFO_DEPTH))
		else $error("result queue overflow");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv && op_s1 |=> (mode_q == M_START) && (word_count_q == 8'd0))
		else $error("end of text did not return the tokenizer to start");

	a_halt_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == M_HALT) && adv && !op_s1 |=> (mode_q == M_HALT) && $stable(count_q)
			|| $past(pop))
		else $error("halted tokenizer produced a result");

	a_empty_no_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) && !adv |=> !m_axis_tvalid)
		else $error("result shown with an empty queue");

endmodule
`default_nettype wire

[tb/fet_tb_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fet_tb_pkg: verification constants for the filter expression tokenizer
// input operation codes and the symbol character set, shared by the stimulus
// and the checker
// ----------------------------------------------------------------------------
package fet_tb_pkg;

	// s_axis_tuser values
	localparam logic OP_CHAR = 1'b0;
	localparam logic OP_EOT  = 1'b1;

	localparam int NUM_SYMBOLS = 10;

	// symbol characters in code order, first character in the top byte
	localparam logic [8*NUM_SYMBOLS-1:0] SYMBOL_SET = "()&|=~<>!?";

	function automatic logic [7:0] symbol_char(input int unsigned code);
		return SYMBOL_SET[8*(NUM_SYMBOLS-1-code) +: 8];
	endfunction

endpackage
`default_nettype wire

[tb/fet_token_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fet_token_checker: scoreboard for the filter expression tokenizer
// watches character and result transfers, predicts the tokens of every
// accepted character and compares each result with the oldest prediction
// ----------------------------------------------------------------------------
module fet_token_checker
	import fet_pkg::*;
	import fet_tb_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	input  wire logic        s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,
	input  wire logic        s_axis_tuser,
	input  wire logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	input  wire logic [95:0] m_axis_tdata,
	input  wire logic [3:0]  m_axis_tuser,
	input  wire logic        m_axis_tlast,
	input  wire logic        cfg_wen,
	input  wire logic [7:0]  cfg_wdata,
	output int               fail_count,
	output int               outstanding,
	output int               live_items
);

	localparam int MAX_REPORTS = 10;

	typedef enum logic [2:0] {
		MD_START,
		MD_NUMBER,
		MD_STRING,
		MD_VARIABLE,
		MD_PATH,
		MD_HALT
	} scan_mode_t;

	scan_mode_t  mode;
	logic [7:0]  max_word;
	logic [7:0]  word_count;
	logic        field_seen;
	logic        hash_word;
	logic        minus_seen;
	logic        is_decimal;
	logic [31:0] int_acc;
	logic [31:0] frac_acc;
	logic [3:0]  frac_count;

	res_t step_res[$];          // tokens of the character being scanned
	res_t expected_tokens[$];   // tokens still owed by the block

	function automatic logic is_numeral(input logic [7:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c == "_");
	endfunction

	function automatic res_t blank(input kind_t k);
		res_t r;
		r = '0;
		r.kind = k;
		return r;
	endfunction

	function automatic string show(input res_t r);
		return $sformatf({"kind=%0d sym=%0d chr=%h neg=%0d int=%h frac=%h ",
			"nfd=%0d fld=%0d len=%0d last=%0d"}, r.kind, r.symbol, r.word_char,
			r.negative, r.int_part, r.frac_part, r.frac_digits, r.has_field,
			r.word_length, r.last);
	endfunction

	task automatic clear_token();
		mode       = MD_START;
		word_count = '0;
		field_seen = 1'b0;
		hash_word  = 1'b0;
		minus_seen = 1'b0;
		is_decimal = 1'b0;
		int_acc    = '0;
		frac_acc   = '0;
		frac_count = '0;
	endtask

	// every character added to a word counts against the limit
	task automatic append_char(input logic [7:0] c);
		res_t r;
		word_count = word_count + 8'd1;
		if (word_count >= max_word) begin
			r = blank(K_TOO_LONG);
			r.word_length = word_count;
			mode = MD_HALT;
		end else begin
			r = blank(K_WORD_CHAR);
		end
		r.word_char = c;
		step_res.push_back(r);
	endtask

	task automatic close_number();
		res_t r;
		if (is_decimal) begin
			r = blank(K_DECIMAL);
			r.frac_part   = frac_acc;
			r.frac_digits = frac_count;
		end else begin
			r = blank(K_INT);
		end
		r.negative = minus_seen;
		r.int_part = int_acc;
		step_res.push_back(r);
		mode = MD_START;
	endtask

	task automatic close_path();
		res_t r;
		r = blank(K_PATH_END);
		r.has_field   = field_seen;
		r.word_length = word_count;
		step_res.push_back(r);
		mode = MD_START;
	endtask

	task automatic finish_word(input kind_t k);
		res_t r;
		r = blank(k);
		r.word_length = word_count;
		step_res.push_back(r);
		mode = MD_START;
	endtask

	task automatic start_token(input logic [7:0] c);
		res_t r;
		int   code;
		code = NUM_SYMBOLS;
		for (int i = 0; i < NUM_SYMBOLS; i++)
			if (symbol_char(i) == c && code == NUM_SYMBOLS)
				code = i;
		if (c == CH_QUOTE) begin
			word_count = '0;
			mode = MD_STRING;
		end else if (c == CH_DOLLAR) begin
			word_count = '0;
			mode = MD_VARIABLE;
		end else if (is_numeral(c) || c == CH_MINUS) begin
			minus_seen = (c == CH_MINUS);
			int_acc    = minus_seen ? 32'd0 : {24'd0, c - CH_ZERO};
			frac_acc   = '0;
			frac_count = '0;
			is_decimal = 1'b0;
			mode = MD_NUMBER;
		end else if (is_letter(c)) begin
			word_count = '0;
			field_seen = 1'b0;
			hash_word  = 1'b0;
			mode = MD_PATH;
			append_char(c);
		end else if (c == CH_SPACE || c == CH_TAB || c == CH_LF) begin
			// blank between tokens
		end else if (code < NUM_SYMBOLS) begin
			r = blank(K_SYMBOL);
			r.symbol = code[3:0];
			step_res.push_back(r);
		end else begin
			r = blank(K_BAD_CHAR);
			r.word_char = c;
			step_res.push_back(r);
			mode = MD_HALT;
		end
	endtask

	task automatic path_step(input logic [7:0] c);
		res_t r;
		logic sep;
		logic stop;
		sep = (c == CH_SLASH) || (c == CH_DOT);
		if (sep)
			stop = field_seen;
		else if (c == CH_HASH)
			stop = (word_count != 0);
		else if (is_numeral(c))
			stop = (word_count == 0);
		else if (is_letter(c))
			stop = hash_word;
		else
			stop = 1'b1;
		if (stop) begin
			close_path();
			start_token(c);
		end else if (sep) begin
			r = blank(K_COMP_END);
			r.word_length = word_count;
			step_res.push_back(r);
			word_count = '0;
			hash_word  = 1'b0;
			if (c == CH_DOT) begin
				field_seen = 1'b1;
				append_char(c);
			end
		end else begin
			if (c == CH_HASH)
				hash_word = 1'b1;
			append_char(c);
		end
	endtask

	task automatic scan_char(input logic [7:0] c);
		case (mode)
			MD_START: start_token(c);
			MD_NUMBER: begin
				if (is_numeral(c)) begin
					if (!is_decimal) begin
						int_acc = int_acc * 32'd10 + {24'd0, c - CH_ZERO};
					end else begin
						frac_acc = frac_acc * 32'd10 + {24'd0, c - CH_ZERO};
						if (frac_count < FRAC_SAT)
							frac_count = frac_count + 4'd1;
					end
				end else if (c == CH_DOT && !is_decimal) begin
					is_decimal = 1'b1;
				end else begin
					close_number();
					start_token(c);
				end
			end
			MD_STRING: begin
				if (c == CH_QUOTE)
					finish_word(K_STR_END);
				else
					append_char(c);
			end
			MD_VARIABLE: begin
				if (is_letter(c) || is_numeral(c)) begin
					append_char(c);
				end else begin
					finish_word(K_VAR_END);
					start_token(c);
				end
			end
			MD_PATH: path_step(c);
			default: ;
		endcase
	endtask

	// end of text closes any open token, then the end token
	task automatic scan_end_of_text();
		case (mode)
			MD_STRING:   finish_word(K_STR_END);
			MD_VARIABLE: finish_word(K_VAR_END);
			MD_NUMBER:   close_number();
			MD_PATH:     close_path();
			default: ;
		endcase
		step_res.push_back(blank(K_END));
		clear_token();
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		res_t  got;
		res_t  want;
		string diffs;
		if (!arst_n) begin
			clear_token();
			max_word = MAX_WORD_RESET;
			expected_tokens.delete();
			fail_count  = 0;
			outstanding = 0;
			live_items  = 0;
		end else begin
			// result transfer
			if (m_axis_tvalid && m_axis_tready) begin
				got = '0;
				got.kind        = kind_t'(m_axis_tuser);
				got.symbol      = m_axis_tdata[3:0];
				got.word_char   = m_axis_tdata[11:4];
				got.negative    = m_axis_tdata[12];
				got.int_part    = m_axis_tdata[44:13];
				got.frac_part   = m_axis_tdata[76:45];
				got.frac_digits = m_axis_tdata[80:77];
				got.has_field   = m_axis_tdata[81];
				got.word_length = m_axis_tdata[89:82];
				got.last        = m_axis_tlast;
				if (expected_tokens.size() == 0) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("unexpected result: %s", show(got));
				end else begin
					want  = expected_tokens.pop_front();
					diffs = "";
					if (got.kind !== want.kind)               diffs = {diffs, " kind"};
					if (got.symbol !== want.symbol)           diffs = {diffs, " symbol"};
					if (got.word_char !== want.word_char)     diffs = {diffs, " word_char"};
					if (got.negative !== want.negative)       diffs = {diffs, " negative"};
					if (got.int_part !== want.int_part)       diffs = {diffs, " int_part"};
					if (got.frac_part !== want.frac_part)     diffs = {diffs, " frac_part"};
					if (got.frac_digits !== want.frac_digits) diffs = {diffs, " frac_digits"};
					if (got.has_field !== want.has_field)     diffs = {diffs, " has_field"};
					if (got.word_length !== want.word_length) diffs = {diffs, " word_length"};
					if (got.last !== want.last)               diffs = {diffs, " last"};
					if (diffs != "") begin
						fail_count++;
						if (fail_count <= MAX_REPORTS) begin
							$display("result mismatch in%s", diffs);
							$display("  expected %s", show(want));
							$display("  actual   %s", show(got));
						end
					end
				end
			end
			if (cfg_wen)
				max_word = cfg_wdata;
			// character transfer
			if (s_axis_tvalid && s_axis_tready) begin
				live_items++;
				step_res.delete();
				if (s_axis_tuser == OP_EOT)
					scan_end_of_text();
				else
					scan_char(s_axis_tdata);
				if (step_res.size() != 0) begin
					want = step_res.pop_back();
					want.last = 1'b1;
					step_res.push_back(want);
				end
				foreach (step_res[i])
					expected_tokens.push_back(step_res[i]);
			end
			outstanding = expected_tokens.size();
		end
	end

endmodule
`default_nettype wire

[tb/tb.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tb: testbench top for the filter expression tokenizer
// drives character and end-of-text transfers (two short directed texts, then
// random filter expressions over several max_word settings), stalls the
// result side at random and leaves all checking to the token checker
// ----------------------------------------------------------------------------
module tb;
	import fet_pkg::*;
	import fet_tb_pkg::*;

	localparam int          ITEM_TARGET  = 1400;    // input transfers in the run
	localparam int          NUM_PHASES   = 8;
	localparam int          DRAIN_CYCLES = 8;       // pipeline depth plus margin
	localparam int unsigned CYCLE_LIMIT  = 800000;

	logic        clk            = 1'b0;
	logic        arst_n         = 1'b0;
	logic        s_axis_tvalid  = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata   = '0;     // [7:0] ch
	logic        s_axis_tuser   = OP_CHAR; // [0] op
	logic        m_axis_tvalid;
	logic        m_axis_tready  = 1'b0;
	logic [95:0] m_axis_tdata;            // symbol, word_char, negative, int_part,
	                                      // frac_part, frac_digits, has_field,
	                                      // word_length from bit 0 up
	logic [3:0]  m_axis_tuser;            // [3:0] kind
	logic        m_axis_tlast;
	logic        cfg_wen        = 1'b0;
	logic [7:0]  cfg_wdata      = '0;

	int fail_count;
	int outstanding;
	int live_items;

	int unsigned cycles       = 0;
	logic [7:0]  cur_max      = MAX_WORD_RESET;  // max_word as last written
	bit          tx_idle_on   = 1'b0;
	bit          rx_stall_on  = 1'b0;
	bit          final_part   = 1'b0;           // last phase runs without idling

	always #5 clk = ~clk;

	filter_expression_tokenizer DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_wen       (cfg_wen),
		.cfg_wdata     (cfg_wdata)
	);

	fet_token_checker token_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_wen       (cfg_wen),
		.cfg_wdata     (cfg_wdata),
		.fail_count    (fail_count),
		.outstanding   (outstanding),
		.live_items    (live_items)
	);

	// watchdog against a hung handshake
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// result side: ready held high, dropped at random into stalls while rx_stall_on is set
	initial begin
		forever begin
			@(negedge clk);
			m_axis_tready = 1'b1;
			repeat ($urandom_range(1, 12) - 1) @(negedge clk);
			if (rx_stall_on && $urandom_range(0, 1) != 0) begin
				@(negedge clk);
				m_axis_tready = 1'b0;
				repeat ($urandom_range(1, 9) - 1) @(negedge clk);
			end
		end
	end

	// one character transfer; entered and left at a falling edge
	task automatic send_item(input logic op, input logic [7:0] c);
		if (tx_idle_on && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid = 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tuser  = op;
		s_axis_tdata  = c;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_item(OP_CHAR, s[i]);
		send_item(OP_EOT, 8'h00);
	endtask

	function automatic logic [7:0] rand_letter();
		int unsigned k;
		k = $urandom_range(0, 52);
		if (k < 26)
			return 8'("a" + k);
		else if (k < 52)
			return 8'("A" + k - 26);
		return "_";
	endfunction

	function automatic logic [7:0] rand_digit();
		return 8'("0" + $urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] rand_alnum();
		if ($urandom_range(0, 2) == 0)
			return rand_digit();
		return rand_letter();
	endfunction

	// any byte but the closing quote, half of them printable
	function automatic logic [7:0] rand_text_byte();
		logic [7:0] b;
		if ($urandom_range(0, 1) != 0)
			b = 8'($urandom_range(32, 126));
		else
			b = 8'($urandom_range(0, 255));
		if (b == CH_QUOTE)
			b = $urandom_range(0, 1) ? 8'hff : 8'h00;
		return b;
	endfunction

	function automatic logic [7:0] rand_blank();
		case ($urandom_range(0, 2))
			0:       return CH_SPACE;
			1:       return CH_TAB;
			default: return CH_LF;
		endcase
	endfunction

	// mostly short words, now and then one that may hit a small limit
	function automatic int pick_word_len();
		if ($urandom_range(0, 4) != 0)
			return int'($urandom_range(0, 5));
		return int'($urandom_range(0, (cur_max < 18) ? cur_max + 2 : 20));
	endfunction

	// one random token with an optional separator after it
	task automatic add_token();
		int unsigned pick;
		int          n;
		bit          neg;
		pick = $urandom_range(0, 99);
		if (pick < 14) begin
			send_item(OP_CHAR, symbol_char($urandom_range(0, NUM_SYMBOLS - 1)));
		end else if (pick < 36) begin
			// number: optional minus, digit runs long enough to wrap and saturate
			neg = ($urandom_range(0, 2) == 0);
			n = ($urandom_range(0, 9) == 0) ? int'($urandom_range(10, 25))
				: int'($urandom_range(0, 4));
			if (neg)
				send_item(OP_CHAR, CH_MINUS);
			else if (n == 0)
				n = 1;
			repeat (n) send_item(OP_CHAR, rand_digit());
			if ($urandom_range(0, 9) < 4) begin
				send_item(OP_CHAR, CH_DOT);
				n = ($urandom_range(0, 7) == 0) ? int'($urandom_range(14, 22))
					: int'($urandom_range(0, 4));
				repeat (n) send_item(OP_CHAR, rand_digit());
				if ($urandom_range(0, 19) == 0)
					send_item(OP_CHAR, CH_DOT);
			end
		end else if (pick < 50) begin
			// quoted string, sometimes left open
			send_item(OP_CHAR, CH_QUOTE);
			repeat (pick_word_len()) send_item(OP_CHAR, rand_text_byte());
			if ($urandom_range(0, 9) != 0)
				send_item(OP_CHAR, CH_QUOTE);
		end else if (pick < 62) begin
			send_item(OP_CHAR, CH_DOLLAR);
			repeat (pick_word_len()) send_item(OP_CHAR, rand_alnum());
		end else if (pick < 88) begin
			// path: leading word, components of letters, hash digits or nothing
			send_item(OP_CHAR, rand_letter());
			repeat (pick_word_len()) send_item(OP_CHAR, rand_letter());
			repeat ($urandom_range(0, 3)) begin
				send_item(OP_CHAR, CH_SLASH);
				case ($urandom_range(0, 3))
					0, 1: repeat ($urandom_range(1, 6)) send_item(OP_CHAR, rand_letter());
					2: begin
						send_item(OP_CHAR, CH_HASH);
						repeat ($urandom_range(0, 3)) send_item(OP_CHAR, rand_digit());
					end
					default: ;
				endcase
			end
			if ($urandom_range(0, 2) == 0) begin
				send_item(OP_CHAR, CH_DOT);
				repeat (pick_word_len()) send_item(OP_CHAR, rand_letter());
			end
		end else if (pick < 95) begin
			repeat ($urandom_range(1, 3)) send_item(OP_CHAR, rand_blank());
		end else begin
			// noise: any byte, usually a bad character
			send_item(OP_CHAR, 8'($urandom_range(0, 255)));
		end
		pick = $urandom_range(0, 9);
		if (pick < 5)
			send_item(OP_CHAR, rand_blank());
		else if (pick < 7)
			send_item(OP_CHAR, symbol_char($urandom_range(0, NUM_SYMBOLS - 1)));
	endtask

	// a run of tokens, usually closed by end of text
	task automatic add_expression();
		tx_idle_on  = !final_part && ($urandom_range(0, 3) != 0);
		rx_stall_on = !final_part && ($urandom_range(0, 3) != 0);
		repeat ($urandom_range(1, 7)) add_token();
		if ($urandom_range(0, 9) != 0)
			send_item(OP_EOT, 8'($urandom_range(0, 255)));
	endtask

	// one word of about max_word characters, either side of the limit
	task automatic add_limit_probe();
		int len;
		len = int'(cur_max) - 1 + int'($urandom_range(0, 2));
		if (len < 0)
			len = 0;
		case ($urandom_range(0, 2))
			0: begin
				send_item(OP_CHAR, CH_QUOTE);
				repeat (len) send_item(OP_CHAR, rand_text_byte());
				send_item(OP_CHAR, CH_QUOTE);
			end
			1: begin
				send_item(OP_CHAR, CH_DOLLAR);
				repeat (len) send_item(OP_CHAR, rand_alnum());
				send_item(OP_CHAR, CH_SPACE);
			end
			default: begin
				// the first letter of a path counts too
				repeat ((len == 0) ? 1 : len) send_item(OP_CHAR, rand_letter());
			end
		endcase
		send_item(OP_EOT, 8'hff);
	endtask

	// config write once the block has gone quiet
	task automatic set_max_word(input logic [7:0] v);
		s_axis_tvalid = 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_wdata = v;
		cfg_wen   = 1'b1;
		@(negedge clk);
		cfg_wen   = 1'b0;
		cur_max   = v;
	endtask

	initial begin
		logic [7:0] plan [NUM_PHASES];
		bit         high_probed;
		high_probed = 1'b0;
		// limits per phase: reset value first, then extremes and small ones
		plan[0] = MAX_WORD_RESET;
		plan[1] = 8'd1;
		plan[2] = 8'd255;
		plan[3] = 8'd0;
		plan[4] = 8'($urandom_range(2, 12));
		plan[5] = MAX_WORD_RESET;
		plan[6] = 8'($urandom_range(3, 8));
		plan[7] = 8'd255;

		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: lone minus, empty fraction, string, variable, path with a
		// hash component, an empty component and a field, end of an open path
		tx_idle_on  = 1'b1;
		rx_stall_on = 1'b1;
		send_text("-\t3.|'a'$v1 ab/#7/.f");
		// second dot: bad character, halt, end of text
		send_text("1..");

		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p > 0)
				set_max_word(plan[p]);
			final_part = (p == NUM_PHASES - 1);
			if (cur_max <= 16 || (cur_max == 255 && !high_probed)) begin
				add_limit_probe();
				high_probed = high_probed || (cur_max == 255);
			end
			while (live_items < ITEM_TARGET * (p + 1) / NUM_PHASES)
				add_expression();
		end
		send_item(OP_EOT, 8'h00);
		s_axis_tvalid = 1'b0;

		// let the last results come out, then a few quiet cycles
		while (outstanding != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
`default_nettype wire
